### rtl/core/hpts_pkg.sv
package hpts_pkg;

    localparam int ANGLE_W = 24;
    localparam int VEL_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // widest term: 24 bit error times 11 bit signed gain, plus one bit of sum headroom
    localparam int SUM_W = 36;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [VEL_W-1:0]   vel_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    localparam cfg_idx_t REG_GOAL_ANGLE      = 3'd0;
    localparam cfg_idx_t REG_MAX_VELOCITY    = 3'd1;
    localparam cfg_idx_t REG_DONE_RANGE      = 3'd2;
    localparam cfg_idx_t REG_HARD_STOP       = 3'd3;
    localparam cfg_idx_t REG_PROP_GAIN       = 3'd4;
    localparam cfg_idx_t REG_INT_GAIN        = 3'd5;
    localparam cfg_idx_t REG_INTEGRAL_LIMIT  = 3'd6;
    localparam cfg_idx_t REG_INTEGRAL_WINDOW = 3'd7;

    localparam logic signed [23:0] RST_GOAL_ANGLE      = 24'sd0;
    localparam logic [9:0]         RST_MAX_VELOCITY    = 10'd200;
    localparam logic [15:0]        RST_DONE_RANGE      = 16'd41;
    localparam logic               RST_HARD_STOP       = 1'b1;
    localparam logic [9:0]         RST_PROP_GAIN       = 10'd300;
    localparam logic [9:0]         RST_INT_GAIN        = 10'd3;
    localparam logic [19:0]        RST_INTEGRAL_LIMIT  = 20'd163840;
    localparam logic [15:0]        RST_INTEGRAL_WINDOW = 16'd2145;

    localparam logic signed [ANGLE_W:0] ANGLE_MAX_EXT = 25'sd8388607;
    localparam logic signed [ANGLE_W:0] ANGLE_MIN_EXT = -25'sd8388608;

endpackage

### rtl/core/heading_pi_turn_with_slew.sv
// heading PI turn controller with wheel slew limiting
//
// input channel: one measured heading (signed Q.ANGLE_FRAC_BITS radians) per
// control tick, moved with in_valid / in_stall. output channel: left and right
// wheel velocity commands plus the done flag, moved with out_valid / out_stall.
// configuration: cfg_valid / cfg_ready with a 3 bit register index and 24 bit
// data; cfg_ready is always high. write registers only while the block is idle.
//
// an accepted heading passes from the input register through one pass of logic
// into the result register. throughput: one transaction per cycle on each side
// while the receiver does not stall; the two gain multipliers, the sum and the
// clamps all sit in that single pass.
// when the receiver stalls, the result register holds and the input register
// still takes one more heading; in_stall rises only when both are full.
// reset clears the integral and the kept wheel speeds, empties both registers
// and loads the configuration registers with their default values.
module heading_pi_turn_with_slew #(
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int SLEW_STEP       = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hpts_pkg::angle_t        measured_heading,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hpts_pkg::vel_t          left_velocity,
    output hpts_pkg::vel_t          right_velocity,
    output logic                    done_res,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  hpts_pkg::cfg_idx_t      cfg_index,
    input  hpts_pkg::cfg_data_t     cfg_data
);
    import hpts_pkg::*;

    localparam logic signed [VEL_W:0] STEP_S = (VEL_W+1)'(SLEW_STEP);

    // configuration registers
    angle_t      goal_angle_reg;
    logic [9:0]  max_velocity_reg;
    logic [15:0] done_range_reg;
    logic        hard_stop_reg;
    logic [9:0]  prop_gain_reg;
    logic [9:0]  int_gain_reg;
    logic [19:0] integral_limit_reg;
    logic [15:0] integral_window_reg;

    // controller state
    angle_t      error_integral_reg;
    vel_t        left_speed_reg;
    vel_t        right_speed_reg;

    // input register holds the already saturated error
    logic        s1_valid_reg;
    angle_t      err_reg;
    angle_t      err_next;

    logic        out_valid_reg;
    vel_t        left_out_reg;
    vel_t        right_out_reg;
    logic        done_out_reg;

    logic        advance;
    logic        in_take;

    logic signed [ANGLE_W:0] diff_in;
    logic [ANGLE_W-1:0]      err_mag;
    logic signed [ANGLE_W:0] int_ext;
    logic signed [ANGLE_W:0] lim_pos;
    logic signed [ANGLE_W:0] lim_neg;
    logic signed [20:0]      int_c;
    logic signed [20:0]      int_k;
    logic                    sign_differs;
    logic                    int_clear;
    logic signed [SUM_W-1:0] p_prod;
    logic signed [SUM_W-1:0] i_prod;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] mv_pos;
    logic signed [SUM_W-1:0] mv_neg;
    vel_t                    pw;
    vel_t                    right_tgt;
    vel_t                    left_tgt;
    logic signed [ANGLE_W:0] int_sum;
    angle_t                  integral_next;
    logic                    done_now;
    vel_t                    left_slew;
    vel_t                    right_slew;
    vel_t                    left_speed_next;
    vel_t                    right_speed_next;

    function automatic vel_t slew_toward(vel_t speed, vel_t target);
        logic signed [VEL_W:0] diff;
        logic signed [VEL_W:0] step;
        logic signed [VEL_W:0] moved;
        diff = {target[VEL_W-1], target} - {speed[VEL_W-1], speed};
        if (diff > STEP_S)
            step = STEP_S;
        else if (diff < -STEP_S)
            step = -STEP_S;
        else
            step = diff;
        // step never overshoots the target, so the result stays in range
        moved = {speed[VEL_W-1], speed} + step;
        return moved[VEL_W-1:0];
    endfunction

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_valid_reg;
    assign left_velocity  = left_out_reg;
    assign right_velocity = right_out_reg;
    assign done_res       = done_out_reg;

    // saturated error at capture
    always_comb
    begin
        diff_in = {goal_angle_reg[ANGLE_W-1], goal_angle_reg}
                - {measured_heading[ANGLE_W-1], measured_heading};
        if (diff_in > ANGLE_MAX_EXT)
            err_next = ANGLE_MAX_EXT[ANGLE_W-1:0];
        else if (diff_in < ANGLE_MIN_EXT)
            err_next = ANGLE_MIN_EXT[ANGLE_W-1:0];
        else
            err_next = diff_in[ANGLE_W-1:0];
    end

    always_comb
    begin
        err_mag = err_reg[ANGLE_W-1] ? (~err_reg + 1'b1) : err_reg;

        // integral clamp, then reset window and sign check
        int_ext = {error_integral_reg[ANGLE_W-1], error_integral_reg};
        lim_pos = $signed({5'b0, integral_limit_reg});
        lim_neg = -lim_pos;
        if (int_ext > lim_pos)
            int_c = lim_pos[20:0];
        else if (int_ext < lim_neg)
            int_c = lim_neg[20:0];
        else
            int_c = int_ext[20:0];

        sign_differs = ((err_reg[ANGLE_W-1]) != (int_c[20]))
                    || ((err_reg == '0) != (int_c == '0));
        int_clear = (err_mag > {8'b0, integral_window_reg}) || sign_differs;
        int_k     = int_clear ? '0 : int_c;

        p_prod = err_reg * $signed({1'b0, prop_gain_reg});
        i_prod = int_k * $signed({1'b0, int_gain_reg});
        sum    = p_prod + i_prod;

        // divide by 2^frac truncating toward zero
        quot = (sum + $signed({{(SUM_W-ANGLE_FRAC_BITS){1'b0}},
                               {ANGLE_FRAC_BITS{sum[SUM_W-1]}}})) >>> ANGLE_FRAC_BITS;

        mv_pos = $signed({{(SUM_W-10){1'b0}}, max_velocity_reg});
        mv_neg = -mv_pos;
        if (quot > mv_pos)
            pw = mv_pos[VEL_W-1:0];
        else if (quot < mv_neg)
            pw = mv_neg[VEL_W-1:0];
        else
            pw = quot[VEL_W-1:0];

        right_tgt = (pw + $signed({{(VEL_W-1){1'b0}}, pw[VEL_W-1]})) >>> 1;
        left_tgt  = -right_tgt;

        int_sum = {{4{int_k[20]}}, int_k} + {err_reg[ANGLE_W-1], err_reg};
        if (int_sum > ANGLE_MAX_EXT)
            integral_next = ANGLE_MAX_EXT[ANGLE_W-1:0];
        else if (int_sum < ANGLE_MIN_EXT)
            integral_next = ANGLE_MIN_EXT[ANGLE_W-1:0];
        else
            integral_next = int_sum[ANGLE_W-1:0];

        left_slew  = slew_toward(left_speed_reg, left_tgt);
        right_slew = slew_toward(right_speed_reg, right_tgt);

        done_now = err_mag < {8'b0, done_range_reg};
        if (done_now && hard_stop_reg)
        begin
            left_speed_next  = '0;
            right_speed_next = '0;
        end
        else
        begin
            left_speed_next  = left_slew;
            right_speed_next = right_slew;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_angle_reg      <= RST_GOAL_ANGLE;
            max_velocity_reg    <= RST_MAX_VELOCITY;
            done_range_reg      <= RST_DONE_RANGE;
            hard_stop_reg       <= RST_HARD_STOP;
            prop_gain_reg       <= RST_PROP_GAIN;
            int_gain_reg        <= RST_INT_GAIN;
            integral_limit_reg  <= RST_INTEGRAL_LIMIT;
            integral_window_reg <= RST_INTEGRAL_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GOAL_ANGLE:      goal_angle_reg      <= cfg_data[23:0];
                REG_MAX_VELOCITY:    max_velocity_reg    <= cfg_data[9:0];
                REG_DONE_RANGE:      done_range_reg      <= cfg_data[15:0];
                REG_HARD_STOP:       hard_stop_reg       <= cfg_data[0];
                REG_PROP_GAIN:       prop_gain_reg       <= cfg_data[9:0];
                REG_INT_GAIN:        int_gain_reg        <= cfg_data[9:0];
                REG_INTEGRAL_LIMIT:  integral_limit_reg  <= cfg_data[19:0];
                REG_INTEGRAL_WINDOW: integral_window_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            error_integral_reg <= '0;
            left_speed_reg     <= '0;
            right_speed_reg    <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                error_integral_reg <= integral_next;
                left_speed_reg     <= left_speed_next;
                right_speed_reg    <= right_speed_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            err_reg <= err_next;
        if (advance)
        begin
            left_out_reg  <= left_speed_next;
            right_out_reg <= right_speed_next;
            done_out_reg  <= done_now;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled while a register was free");

    a_hard_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res && hard_stop_reg) |-> (left_velocity == '0 && right_velocity == '0))
        else $error("done with hard stop but wheels not zeroed");

    a_wheels_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_velocity == -right_velocity))
        else $error("wheel commands not opposite");

    a_state_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> (left_speed_reg == left_out_reg && right_speed_reg == right_out_reg))
        else $error("kept speeds differ from delivered result");
`endif

endmodule

### bench/tb_heading_pi_turn_with_slew.sv
`timescale 1ns / 100ps

module tb_heading_pi_turn_with_slew;
    import hpts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SLEW = 3;
    localparam longint Q_ONE = 64'sd1 <<< 12;
    localparam longint ANG_LO = -64'sd8388608;
    localparam longint ANG_HI = 64'sd8388607;

    typedef struct packed {
        vel_t left;
        vel_t right;
        logic done;
    } wheel_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    angle_t    measured_heading = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    vel_t      left_velocity;
    vel_t      right_velocity;
    logic      done_res;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = REG_GOAL_ANGLE;
    cfg_data_t cfg_data = '0;

    // controller settings as last written
    angle_t      goal_set   = RST_GOAL_ANGLE;
    logic [9:0]  vmax_set   = RST_MAX_VELOCITY;
    logic [15:0] drange_set = RST_DONE_RANGE;
    logic        hstop_set  = RST_HARD_STOP;
    logic [9:0]  kp_set     = RST_PROP_GAIN;
    logic [9:0]  ki_set     = RST_INT_GAIN;
    logic [19:0] ilim_set   = RST_INTEGRAL_LIMIT;
    logic [15:0] iwin_set   = RST_INTEGRAL_WINDOW;

    // controller state carried from tick to tick
    angle_t integ_acc  = '0;
    vel_t   left_kept  = '0;
    vel_t   right_kept = '0;

    angle_t     heading_q[$];
    wheel_cmd_t cmd_q[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;

    heading_pi_turn_with_slew dut (.*);

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic int signum(longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic longint magn(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // one control tick: PI on the heading error, then slew both wheels
    function automatic wheel_cmd_t turn_tick(angle_t heading);
        longint     err;
        longint     acc;
        longint     lim;
        longint     pw;
        longint     lt;
        longint     rt;
        longint     ls;
        longint     rs;
        wheel_cmd_t cmd;
        err = clip(longint'(goal_set) - longint'(heading), ANG_LO, ANG_HI);
        lim = longint'(ilim_set);
        acc = clip(longint'(integ_acc), -lim, lim);
        if (magn(err) > longint'(iwin_set) || signum(err) != signum(acc))
            acc = 0;
        pw = (err * longint'(kp_set) + acc * longint'(ki_set)) / Q_ONE;
        pw = clip(pw, -longint'(vmax_set), longint'(vmax_set));
        integ_acc = angle_t'(clip(acc + err, ANG_LO, ANG_HI));
        lt = -(pw / 2);
        rt = pw / 2;
        ls = longint'(left_kept);
        rs = longint'(right_kept);
        ls = clip(ls + clip(lt - ls, -SLEW, SLEW), -1024, 1023);
        rs = clip(rs + clip(rt - rs, -SLEW, SLEW), -1024, 1023);
        cmd.done = magn(err) < longint'(drange_set);
        if (cmd.done && hstop_set) begin
            ls = 0;
            rs = 0;
        end
        left_kept = vel_t'(ls);
        right_kept = vel_t'(rs);
        cmd.left = left_kept;
        cmd.right = right_kept;
        return cmd;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // called at a rising edge; leaves cfg_valid high for a following write
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GOAL_ANGLE:      goal_set = angle_t'(val);
            REG_MAX_VELOCITY:    vmax_set = val[9:0];
            REG_DONE_RANGE:      drange_set = val[15:0];
            REG_HARD_STOP:       hstop_set = val[0];
            REG_PROP_GAIN:       kp_set = val[9:0];
            REG_INT_GAIN:        ki_set = val[9:0];
            REG_INTEGRAL_LIMIT:  ilim_set = val[19:0];
            REG_INTEGRAL_WINDOW: iwin_set = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(cfg_data_t goal_v, vmax_v, drange_v, stop_v,
                               kp_v, ki_v, lim_v, win_v);
        write_reg(REG_GOAL_ANGLE, goal_v);
        write_reg(REG_MAX_VELOCITY, vmax_v);
        write_reg(REG_DONE_RANGE, drange_v);
        write_reg(REG_HARD_STOP, stop_v);
        write_reg(REG_PROP_GAIN, kp_v);
        write_reg(REG_INT_GAIN, ki_v);
        write_reg(REG_INTEGRAL_LIMIT, lim_v);
        write_reg(REG_INTEGRAL_WINDOW, win_v);
        cfg_valid <= 1'b0;
    endtask

    // wait until every heading went in and every command came out
    task automatic settle();
        do @(negedge clk);
        while (heading_q.size() != 0 || in_valid || cmd_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // extremes now and then, a typical span mostly, junk above the field sometimes
    function automatic cfg_data_t pick(int unsigned width, int unsigned top,
                                       int unsigned usual);
        cfg_data_t v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = cfg_data_t'(top);
            2: v = cfg_data_t'($urandom_range(top));
            default: v = cfg_data_t'($urandom_range(usual));
        endcase
        if ($urandom_range(9) == 0)
            v = v | (cfg_data_t'($urandom()) << width);
        return v;
    endfunction

    // heading driver
    always @(posedge clk) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else begin
            if (in_valid && !in_stall)
                cmd_q.push_back(turn_tick(measured_heading));
            if (!in_valid || !in_stall) begin
                if (heading_q.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
                    in_valid <= 1'b1;
                    measured_heading <= heading_q.pop_front();
                end else
                    in_valid <= 1'b0;
            end
        end
    end

    // wheel command monitor
    always @(posedge clk) begin : cmd_monitor
        wheel_cmd_t want;
        if (rst_n) begin
            out_stall <= !calm && $urandom_range(99) < 7;
            if (out_valid && !out_stall) begin
                if (cmd_q.size() == 0)
                    flag_mismatch("wheel command with nothing expected");
                else begin
                    want = cmd_q.pop_front();
                    if (left_velocity !== want.left)
                        flag_mismatch($sformatf("left_velocity %0d, expected %0d",
                                                left_velocity, want.left));
                    if (right_velocity !== want.right)
                        flag_mismatch($sformatf("right_velocity %0d, expected %0d",
                                                right_velocity, want.right));
                    if (done_res !== want.done)
                        flag_mismatch($sformatf("done_res %b, expected %b",
                                                done_res, want.done));
                end
            end
        end
    end

    // no transaction on any channel for too long means the block hung
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int        basic_pts[] = '{0, 30, -30, 41, -41, 500, 500, 500, 500, 0,
                                   2146, -2145, 8388607, -8388608, 24'h555555};
        int        extreme_pts[] = '{-8388608, 8388607, 8328607, 8328607, 8328607, -1};
        int        e;
        int        mode;
        cfg_data_t g;
        angle_t    h;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: done with hard stop, integral build-up then zero error
        foreach (basic_pts[i])
            heading_q.push_back(angle_t'(basic_pts[i]));
        settle();

        // everything at its top: saturated error, no done range, no hard stop
        apply_setup(24'h7FFFFF, 10'd1023, 16'd0, 1'b0, 10'd1023, 10'd1023,
                    20'hFFFFF, 16'hFFFF);
        foreach (extreme_pts[i])
            heading_q.push_back(angle_t'(extreme_pts[i]));
        settle();

        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph == 6);
            case ($urandom_range(3))
                0: g = 24'h7FFFFF;
                1: g = 24'h800000;
                default: g = cfg_data_t'($urandom());
            endcase
            apply_setup(g, pick(10, 1023, 600), pick(16, 65535, 400), pick(1, 1, 1),
                        pick(10, 1023, 1023), pick(10, 1023, 64),
                        pick(20, 20'hFFFFF, 200000), pick(16, 65535, 5000));
            mode = $urandom_range(3);
            e = int'($urandom_range(8000)) - 4000;
            repeat (98) begin
                if (mode == 0 || $urandom_range(19) == 0)
                    h = angle_t'($urandom());
                else begin
                    // error decays toward zero with jitter, which can flip its sign, and now and then jumps
                    if ($urandom_range(15) == 0)
                        e = int'($urandom_range(140000)) - 70000;
                    else
                        e = e - e / 8 + int'($urandom_range(40)) - 20;
                    h = angle_t'(int'(goal_set) - e);
                end
                heading_q.push_back(h);
            end
            settle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/core/hpts_pkg.sv
rtl/core/heading_pi_turn_with_slew.sv
bench/tb_heading_pi_turn_with_slew.sv
